### design/i2p_pkg.sv
`default_nettype none

package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  localparam int OPN_W  = 3;
  localparam int SYM_W  = 4;
  localparam int VAL_W  = 64;
  localparam int KIND_W = 2;
  localparam int ERR_W  = 3;
  localparam int ENT_W  = 5;
  localparam int PREC_W = 3;

  // stack entry codes: operators 0..7, functions 8..17, open parenthesis
  localparam logic [ENT_W-1:0] ENT_FUNC_BASE = 5'd8;
  localparam logic [ENT_W-1:0] ENT_OPEN      = 5'd31;

  localparam logic [SYM_W-1:0] OP_SYM_MAX = 4'd7;
  localparam logic [SYM_W-1:0] FN_SYM_MAX = 4'd9;

  localparam logic [PREC_W-1:0] LEFT_ASSOC_MAX = 3'd3;

  typedef enum logic [OPN_W-1:0] {
    OPN_NUMBER   = 3'd0,
    OPN_OPERATOR = 3'd1,
    OPN_FUNCTION = 3'd2,
    OPN_OPEN     = 3'd3,
    OPN_CLOSE    = 3'd4,
    OPN_COMMA    = 3'd5,
    OPN_END      = 3'd6
  } opn_t;

  typedef enum logic [2:0] {
    OPC_PLUS      = 3'd0,
    OPC_MINUS     = 3'd1,
    OPC_TIMES     = 3'd2,
    OPC_DIVIDE    = 3'd3,
    OPC_MODULO    = 3'd4,
    OPC_POWER     = 3'd5,
    OPC_NEGATE    = 3'd6,
    OPC_FACTORIAL = 3'd7
  } opc_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NUMBER   = 2'd0,
    KIND_OPERATOR = 2'd1,
    KIND_FUNCTION = 2'd2,
    KIND_STATUS   = 2'd3
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE            = 3'd0,
    ERR_UNMATCHED_CLOSE = 3'd1,
    ERR_STRAY_COMMA     = 3'd2,
    ERR_UNMATCHED_OPEN  = 3'd3,
    ERR_OVERFLOW        = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    RES_NONE   = 2'd0,
    RES_ENTRY  = 2'd1,
    RES_NUMBER = 2'd2,
    RES_STATUS = 2'd3
  } res_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_RUN      = 2'd1,
    ST_FUNC_CHK = 2'd2,
    ST_DRAIN    = 2'd3
  } state_t;

  typedef struct packed {
    logic     load;
    logic     pop;
    logic     drop;
    logic     push;
    logic     clear;
    res_sel_t res;
    err_t     err;
    logic     drain;
  } dp_cmd_t;

  typedef struct packed {
    logic [OPN_W-1:0] op;
    logic             sym_bad_op;
    logic             sym_bad_fn;
    logic             empty;
    logic             full;
    logic             top_open;
    logic             top_func;
    logic             top_go;
    logic             pend_valid;
    logic             out_free;
  } dp_stat_t;

  function automatic logic [PREC_W-1:0] prec(input logic [2:0] code);
    logic [PREC_W-1:0] p;
    case (code)
      OPC_PLUS, OPC_MINUS:    p = 3'd1;
      OPC_TIMES, OPC_DIVIDE:  p = 3'd3;
      OPC_MODULO:             p = 3'd2;
      OPC_POWER, OPC_NEGATE:  p = 3'd4;
      OPC_FACTORIAL:          p = 3'd5;
      default:                p = 3'd1;
    endcase
    return p;
  endfunction

  // incoming level p pops stacked level q
  function automatic logic pops(input logic [PREC_W-1:0] p, input logic [PREC_W-1:0] q);
    return (p <= LEFT_ASSOC_MAX) ? (p <= q) : (p < q);
  endfunction

endpackage

`default_nettype wire

### design/i2p_if.sv
`default_nettype none

interface i2p_in_if;
  logic                       valid;
  logic                       ready;
  logic [i2p_pkg::OPN_W-1:0]  operation;
  logic [i2p_pkg::SYM_W-1:0]  symbol;
  logic [i2p_pkg::VAL_W-1:0]  number_value;

  modport source (output valid, output operation, output symbol, output number_value,
                  input ready);
  modport sink (input valid, input operation, input symbol, input number_value,
                output ready);
endinterface

interface i2p_out_if;
  logic                        valid;
  logic                        ready;
  logic [i2p_pkg::KIND_W-1:0]  out_kind;
  logic [i2p_pkg::SYM_W-1:0]   out_symbol;
  logic [i2p_pkg::VAL_W-1:0]   out_value;
  logic                        last_of_run;
  logic [i2p_pkg::ERR_W-1:0]   error_code;

  modport source (output valid, output out_kind, output out_symbol, output out_value,
                  output last_of_run, output error_code, input ready);
  modport sink (input valid, input out_kind, input out_symbol, input out_value,
                input last_of_run, input error_code, output ready);
endinterface

`default_nettype wire

### design/infix_to_postfix_converter_core.sv
// Shunting-yard converter: infix tokens in on in_chan, postfix tokens out on
// out_chan, both valid/ready channels; an item moves when valid and ready are
// both high at a rising edge of clk.
// Numbers come straight out. Operators pop entries of higher precedence (or
// equal, when left-associative) off a 32-entry stack, then are pushed. Close,
// comma and end pop down to an open parenthesis; end also adds one status
// result. Errors give a status result and empty the stack. The last result of
// each input item carries last_of_run; ignored tokens and tokens that only
// push give no result.
// Timing: in_chan.ready is high only between items. An item takes one step
// per pop plus a last step (push, status or stop at an open parenthesis), and
// a close that finds its parenthesis a further step to look for a function.
// Results add a drain step that moves the last one to the output register;
// the next item is taken only after that (or after the last step with no
// result). Pops go one at a time, as the stack memory has a single read port.
// When out_chan.ready is low, the output register keeps its item, and while
// a result is held and that register is full the block waits for it.
// rst_n (synchronous, active low) empties the stack and drops any result in
// flight; the stack memory itself needs no clearing.
`default_nettype none

module infix_to_postfix_converter_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  i2p_in_if.sink     in_chan,
  i2p_out_if.source  out_chan
);

  import i2p_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     ctrl_ready;

  assign in_chan.ready = ctrl_ready;

  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (ctrl_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  i2p_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_chan.operation),
    .in_symbol       (in_chan.symbol),
    .in_number_value (in_chan.number_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_chan        (out_chan)
  );

endmodule

`default_nettype wire

### design/i2p_ram.sv
`default_nettype none

module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/i2p_datapath.sv
`default_nettype none

module i2p_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [i2p_pkg::OPN_W-1:0] in_operation,
  input  wire logic [i2p_pkg::SYM_W-1:0] in_symbol,
  input  wire logic [i2p_pkg::VAL_W-1:0] in_number_value,
  input  wire i2p_pkg::dp_cmd_t          cmd,
  output i2p_pkg::dp_stat_t              stat,
  i2p_out_if.source                      out_chan
);

  import i2p_pkg::*;

  logic [OPN_W-1:0]  op_r;
  logic [SYM_W-1:0]  sym_r;
  logic [VAL_W-1:0]  val_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_m1;
  logic [ENT_W-1:0]  top;
  logic [ENT_W-1:0]  wr_ent;
  logic [ENT_W-1:0]  fn_ent;
  logic              top_op;

  // held result, sent once it is known whether another follows
  logic              pend_valid_r;
  kind_t             pend_kind_r;
  logic [SYM_W-1:0]  pend_sym_r;
  logic [VAL_W-1:0]  pend_val_r;
  err_t              pend_err_r;

  kind_t             res_kind;
  logic [SYM_W-1:0]  res_sym;
  logic [VAL_W-1:0]  res_val;
  err_t              res_err;

  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [SYM_W-1:0]  out_sym_r;
  logic [VAL_W-1:0]  out_val_r;
  logic              out_last_r;
  logic [ERR_W-1:0]  out_err_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clear) begin
      cnt_nxt = '0;
    end else if (cmd.push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.pop || cmd.drop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // read ahead so the data holds the top of the stack seen next cycle (not after a push)
  assign cnt_m1 = cnt_nxt - CNT_W'(1);

  always_comb begin
    case (op_r)
      OPN_OPERATOR: wr_ent = {1'b0, sym_r};
      OPN_FUNCTION: wr_ent = ENT_FUNC_BASE + {1'b0, sym_r};
      default:      wr_ent = ENT_OPEN;
    endcase
  end

  i2p_ram #(
    .WIDTH (ENT_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (wr_ent),
    .raddr (cnt_m1[ADDR_W-1:0]),
    .rdata (top)
  );

  assign top_op = (top < ENT_FUNC_BASE);
  assign fn_ent = top - ENT_FUNC_BASE;

  always_comb begin
    stat.op         = op_r;
    stat.sym_bad_op = (sym_r > OP_SYM_MAX);
    stat.sym_bad_fn = (sym_r > FN_SYM_MAX);
    stat.empty      = (cnt_r == '0);
    stat.full       = (cnt_r == CNT_W'(STACK_DEPTH));
    stat.top_open   = (top == ENT_OPEN);
    stat.top_func   = !top_op && (top != ENT_OPEN);
    stat.top_go     = top_op && pops(prec(sym_r[2:0]), prec(top[2:0]));
    stat.pend_valid = pend_valid_r;
    stat.out_free   = !out_valid_r || out_chan.ready;
  end

  always_comb begin
    res_kind = KIND_STATUS;
    res_sym  = '0;
    res_val  = '0;
    res_err  = ERR_NONE;
    case (cmd.res)
      RES_ENTRY: begin
        if (top_op) begin
          res_kind = KIND_OPERATOR;
          res_sym  = top[SYM_W-1:0];
        end else begin
          res_kind = KIND_FUNCTION;
          res_sym  = fn_ent[SYM_W-1:0];
        end
      end
      RES_NUMBER: begin
        res_kind = KIND_NUMBER;
        res_val  = val_r;
      end
      RES_STATUS: res_err = cmd.err;
      default: res_err = ERR_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      sym_r <= in_symbol;
      val_r <= in_number_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.res != RES_NONE) begin
        pend_valid_r <= 1'b1;
        if (pend_valid_r) begin
          out_valid_r <= 1'b1;
        end else if (out_chan.ready) begin
          out_valid_r <= 1'b0;
        end
      end else if (cmd.drain) begin
        pend_valid_r <= 1'b0;
        out_valid_r  <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res != RES_NONE) begin
      pend_kind_r <= res_kind;
      pend_sym_r  <= res_sym;
      pend_val_r  <= res_val;
      pend_err_r  <= res_err;
    end
    if ((cmd.res != RES_NONE && pend_valid_r) || cmd.drain) begin
      out_kind_r <= pend_kind_r;
      out_sym_r  <= pend_sym_r;
      out_val_r  <= pend_val_r;
      out_err_r  <= pend_err_r;
      out_last_r <= cmd.drain;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_kind    = out_kind_r;
  assign out_chan.out_symbol  = out_sym_r;
  assign out_chan.out_value   = out_val_r;
  assign out_chan.last_of_run = out_last_r;
  assign out_chan.error_code  = out_err_r;

endmodule

`default_nettype wire

### design/i2p_ctrl.sv
`default_nettype none

module i2p_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire i2p_pkg::dp_stat_t stat,
  output i2p_pkg::dp_cmd_t       cmd
);

  import i2p_pkg::*;

  state_t state_r, state_nxt;
  logic   step_ok;
  state_t done_state;

  assign step_ok    = !stat.pend_valid || stat.out_free;
  assign done_state = stat.pend_valid ? ST_DRAIN : ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res   = RES_NONE;
    cmd.err   = ERR_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end

      ST_RUN: begin
        if (step_ok) begin
          case (stat.op)
            OPN_NUMBER: begin
              cmd.res   = RES_NUMBER;
              state_nxt = ST_DRAIN;
            end
            OPN_OPERATOR: begin
              if (stat.sym_bad_op) begin
                state_nxt = ST_IDLE;
              end else if (!stat.empty && stat.top_go) begin
                cmd.pop = 1'b1;
                cmd.res = RES_ENTRY;
              end else if (stat.full) begin
                cmd.res   = RES_STATUS;
                cmd.err   = ERR_OVERFLOW;
                cmd.clear = 1'b1;
                state_nxt = ST_DRAIN;
              end else begin
                cmd.push  = 1'b1;
                state_nxt = done_state;
              end
            end
            OPN_FUNCTION, OPN_OPEN: begin
              if (stat.op == OPN_FUNCTION && stat.sym_bad_fn) begin
                state_nxt = ST_IDLE;
              end else if (stat.full) begin
                cmd.res   = RES_STATUS;
                cmd.err   = ERR_OVERFLOW;
                cmd.clear = 1'b1;
                state_nxt = ST_DRAIN;
              end else begin
                cmd.push  = 1'b1;
                state_nxt = ST_IDLE;
              end
            end
            OPN_CLOSE: begin
              if (stat.empty) begin
                cmd.res   = RES_STATUS;
                cmd.err   = ERR_UNMATCHED_CLOSE;
                cmd.clear = 1'b1;
                state_nxt = ST_DRAIN;
              end else if (stat.top_open) begin
                cmd.drop  = 1'b1;
                state_nxt = ST_FUNC_CHK;
              end else begin
                cmd.pop = 1'b1;
                cmd.res = RES_ENTRY;
              end
            end
            OPN_COMMA: begin
              if (stat.empty) begin
                cmd.res   = RES_STATUS;
                cmd.err   = ERR_STRAY_COMMA;
                cmd.clear = 1'b1;
                state_nxt = ST_DRAIN;
              end else if (stat.top_open) begin
                state_nxt = done_state;
              end else begin
                cmd.pop = 1'b1;
                cmd.res = RES_ENTRY;
              end
            end
            OPN_END: begin
              if (stat.empty) begin
                cmd.res   = RES_STATUS;
                cmd.err   = ERR_NONE;
                state_nxt = ST_DRAIN;
              end else if (stat.top_open) begin
                cmd.res   = RES_STATUS;
                cmd.err   = ERR_UNMATCHED_OPEN;
                cmd.clear = 1'b1;
                state_nxt = ST_DRAIN;
              end else begin
                cmd.pop = 1'b1;
                cmd.res = RES_ENTRY;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      // a function right under the matched open parenthesis goes out too
      ST_FUNC_CHK: begin
        if (step_ok) begin
          if (!stat.empty && stat.top_func) begin
            cmd.pop   = 1'b1;
            cmd.res   = RES_ENTRY;
            state_nxt = ST_DRAIN;
          end else begin
            state_nxt = done_state;
          end
        end
      end

      ST_DRAIN: begin
        if (stat.out_free) begin
          cmd.drain = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire
